FILE: design/bacg_pkg.sv
// Shared types and constants of the block affine coordinate generator.
package bacg_pkg;

   localparam int COEF_W    = 32;
   localparam int COORD_W   = 16;
   localparam int FRAC_BITS = 16;
   localparam int DIM_W     = 13;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_XX      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_XY      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_YX      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_YY      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y     = 3'd7;

   localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sd65536;
   localparam logic signed [COEF_W-1:0] COEF_ZERO = 32'sd0;

   typedef struct packed {
      logic load;
      logic sum;
   } stage_en_type;

endpackage

FILE: design/bacg_affine.sv
// Two-stage affine term: registered products, then registered sum with truncation to 16 bits.
module bacg_affine #(
   parameter int CW = 13,
   parameter int RW = 13
) (
   input  logic                              clock,
   input  bacg_pkg::stage_en_type            en,
   input  logic signed [bacg_pkg::COEF_W-1:0] coef_col,
   input  logic signed [bacg_pkg::COEF_W-1:0] coef_row,
   input  logic signed [bacg_pkg::COEF_W-1:0] offset,
   input  logic [CW-1:0]                     col,
   input  logic [RW-1:0]                     row,
   output logic signed [bacg_pkg::COORD_W-1:0] coord
);

   localparam int MW = (CW > RW) ? CW : RW;
   localparam int SW = bacg_pkg::COEF_W + MW + 3;

   logic signed [bacg_pkg::COEF_W+CW:0]  prod_col_ff, prod_col_in;
   logic signed [bacg_pkg::COEF_W+RW:0]  prod_row_ff, prod_row_in;
   logic signed [SW-1:0]                 sum;
   logic                                 round_up;
   logic signed [bacg_pkg::COORD_W-1:0]  coord_ff, coord_in;

   assign prod_col_in = coef_col * $signed({1'b0, col});
   assign prod_row_in = coef_row * $signed({1'b0, row});

   assign sum = SW'(prod_col_ff) + SW'(prod_row_ff) + SW'(offset);
   assign round_up = sum[SW-1] && (sum[bacg_pkg::FRAC_BITS-1:0] != '0);
   assign coord_in = sum[bacg_pkg::FRAC_BITS +: bacg_pkg::COORD_W]
                     + bacg_pkg::COORD_W'(round_up);

   always_ff @(posedge clock) begin
      if (en.load) begin
         prod_col_ff <= prod_col_in;
         prod_row_ff <= prod_row_in;
      end
      if (en.sum) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

FILE: design/block_affine_coordinate_generator_top.sv
// Block-order affine source coordinate generator: pixel walker, affine units, block minimum.
// An accepted request passes the product, sum and result registers before rsp_valid.
// Throughput: one request per cycle while rsp_stall is low (pipelined affine multiply-add).
// Each stage advances when the next is empty or moving, so bubbles absorb stalls.
// Reset (synchronous, active high): position to frame origin, pipeline empty,
// registers to their defaults (sizes 0, unit coefficients on the diagonal).
module block_affine_coordinate_generator_top #(
   parameter int BLOCK_SIZE = 32,
   parameter int MAX_COLS   = 4096,
   parameter int MAX_ROWS   = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bacg_pkg::COORD_W-1:0]  rsp_src_x,
   output logic signed [bacg_pkg::COORD_W-1:0]  rsp_src_y,
   output logic                                 rsp_block_last,
   output logic signed [bacg_pkg::COORD_W-1:0]  rsp_block_min_x,
   output logic signed [bacg_pkg::COORD_W-1:0]  rsp_block_min_y,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bacg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bacg_pkg::COEF_W-1:0]          csr_data
);

   localparam int CW   = $clog2(MAX_COLS + BLOCK_SIZE);
   localparam int RW   = $clog2(MAX_ROWS + BLOCK_SIZE);
   localparam int IBW  = (BLOCK_SIZE > 2) ? $clog2(BLOCK_SIZE) : 1;
   localparam int XW_C = ((CW > bacg_pkg::DIM_W) ? CW : bacg_pkg::DIM_W) + 1;
   localparam int XW_R = ((RW > bacg_pkg::DIM_W) ? RW : bacg_pkg::DIM_W) + 1;
   localparam logic [IBW-1:0] IB_LAST = IBW'(BLOCK_SIZE - 1);

   // configuration
   logic [bacg_pkg::DIM_W-1:0]         frame_width_ff, frame_height_ff;
   logic signed [bacg_pkg::COEF_W-1:0] coef_xx_ff, coef_xy_ff, offset_x_ff;
   logic signed [bacg_pkg::COEF_W-1:0] coef_yx_ff, coef_yy_ff, offset_y_ff;

   // pixel walker
   logic [CW-1:0]  org_col_ff, org_col_in, col_ff, col_in, cur_org_col, cur_col;
   logic [RW-1:0]  org_row_ff, org_row_in, row_ff, row_in, cur_org_row, cur_row;
   logic [IBW-1:0] cib_ff, cib_in, cur_cib;
   logic [IBW-1:0] rib_ff, rib_in, cur_rib;
   logic [XW_C-1:0] width_sat;
   logic [XW_R-1:0] height_sat;
   logic           accept, blast, flast, first, last_col, last_row;

   // pipeline control
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic adv1, adv2, adv3, load3;
   bacg_pkg::stage_en_type en;
   logic blast1_ff, flast1_ff, first1_ff;
   logic blast2_ff, flast2_ff, first2_ff;

   // affine results and block minimum
   logic signed [bacg_pkg::COORD_W-1:0] x2, y2;
   logic signed [bacg_pkg::COORD_W-1:0] min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic signed [bacg_pkg::COORD_W-1:0] src_x_ff, src_y_ff, bmin_x_ff, bmin_y_ff;
   logic blast3_ff, flast3_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
         coef_xx_ff      <= bacg_pkg::COEF_ONE;
         coef_xy_ff      <= bacg_pkg::COEF_ZERO;
         offset_x_ff     <= bacg_pkg::COEF_ZERO;
         coef_yx_ff      <= bacg_pkg::COEF_ZERO;
         coef_yy_ff      <= bacg_pkg::COEF_ONE;
         offset_y_ff     <= bacg_pkg::COEF_ZERO;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bacg_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[bacg_pkg::DIM_W-1:0];
            bacg_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[bacg_pkg::DIM_W-1:0];
            bacg_pkg::CSR_COEF_XX:      coef_xx_ff      <= csr_data;
            bacg_pkg::CSR_COEF_XY:      coef_xy_ff      <= csr_data;
            bacg_pkg::CSR_OFFSET_X:     offset_x_ff     <= csr_data;
            bacg_pkg::CSR_COEF_YX:      coef_yx_ff      <= csr_data;
            bacg_pkg::CSR_COEF_YY:      coef_yy_ff      <= csr_data;
            bacg_pkg::CSR_OFFSET_Y:     offset_y_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance
   assign adv3      = !v3_ff || !rsp_stall;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1;
   assign accept    = req_valid && !req_stall;
   assign en.load   = accept;
   assign en.sum    = v1_ff && adv2;
   assign load3     = v2_ff && adv3;
   assign v1_in     = adv1 ? accept : v1_ff;
   assign v2_in     = adv2 ? v1_ff : v2_ff;
   assign v3_in     = adv3 ? v2_ff : v3_ff;

   // current position, cleared by restart
   always_comb begin
      if (req_restart) begin
         cur_org_col = '0;
         cur_org_row = '0;
         cur_col     = '0;
         cur_row     = '0;
         cur_cib     = '0;
         cur_rib     = '0;
      end else begin
         cur_org_col = org_col_ff;
         cur_org_row = org_row_ff;
         cur_col     = col_ff;
         cur_row     = row_ff;
         cur_cib     = cib_ff;
         cur_rib     = rib_ff;
      end
   end

   assign width_sat  = (XW_C'(frame_width_ff) > XW_C'(MAX_COLS)) ?
                       XW_C'(MAX_COLS) : XW_C'(frame_width_ff);
   assign height_sat = (XW_R'(frame_height_ff) > XW_R'(MAX_ROWS)) ?
                       XW_R'(MAX_ROWS) : XW_R'(frame_height_ff);
   assign last_col   = (XW_C'(cur_org_col) + XW_C'(BLOCK_SIZE)) >= width_sat;
   assign last_row   = (XW_R'(cur_org_row) + XW_R'(BLOCK_SIZE)) >= height_sat;
   assign first      = (cur_cib == '0) && (cur_rib == '0);
   assign blast      = (cur_cib == IB_LAST) && (cur_rib == IB_LAST);
   assign flast      = blast && last_col && last_row;

   // advance to the next pixel in block order
   always_comb begin
      org_col_in = cur_org_col;
      org_row_in = cur_org_row;
      col_in     = cur_col + CW'(1);
      row_in     = cur_row;
      cib_in     = cur_cib + IBW'(1);
      rib_in     = cur_rib;
      if (blast) begin
         cib_in = '0;
         rib_in = '0;
         if (!last_col) begin
            org_col_in = cur_org_col + CW'(BLOCK_SIZE);
            col_in     = cur_org_col + CW'(BLOCK_SIZE);
            row_in     = cur_org_row;
         end else begin
            org_col_in = '0;
            col_in     = '0;
            if (!last_row) begin
               org_row_in = cur_org_row + RW'(BLOCK_SIZE);
               row_in     = cur_org_row + RW'(BLOCK_SIZE);
            end else begin
               org_row_in = '0;
               row_in     = '0;
            end
         end
      end else if (cur_cib == IB_LAST) begin
         cib_in = '0;
         rib_in = cur_rib + IBW'(1);
         col_in = cur_org_col;
         row_in = cur_row + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         org_col_ff <= '0;
         org_row_ff <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         cib_ff     <= '0;
         rib_ff     <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
      end else begin
         if (accept) begin
            org_col_ff <= org_col_in;
            org_row_ff <= org_row_in;
            col_ff     <= col_in;
            row_ff     <= row_in;
            cib_ff     <= cib_in;
            rib_ff     <= rib_in;
         end
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   bacg_affine #(.CW(CW), .RW(RW)) u_affine_x (
      .clock    (clock),
      .en       (en),
      .coef_col (coef_xx_ff),
      .coef_row (coef_xy_ff),
      .offset   (offset_x_ff),
      .col      (cur_col),
      .row      (cur_row),
      .coord    (x2)
   );

   bacg_affine #(.CW(CW), .RW(RW)) u_affine_y (
      .clock    (clock),
      .en       (en),
      .coef_col (coef_yx_ff),
      .coef_row (coef_yy_ff),
      .offset   (offset_y_ff),
      .col      (cur_col),
      .row      (cur_row),
      .coord    (y2)
   );

   // block minimum, restarted at the first pixel of each block
   assign min_x_in = (first2_ff || (x2 < min_x_ff)) ? x2 : min_x_ff;
   assign min_y_in = (first2_ff || (y2 < min_y_ff)) ? y2 : min_y_ff;

   always_ff @(posedge clock) begin
      if (en.load) begin
         blast1_ff <= blast;
         flast1_ff <= flast;
         first1_ff <= first;
      end
      if (en.sum) begin
         blast2_ff <= blast1_ff;
         flast2_ff <= flast1_ff;
         first2_ff <= first1_ff;
      end
      if (load3) begin
         min_x_ff  <= min_x_in;
         min_y_ff  <= min_y_in;
         src_x_ff  <= x2;
         src_y_ff  <= y2;
         blast3_ff <= blast2_ff;
         flast3_ff <= flast2_ff;
         bmin_x_ff <= blast2_ff ? min_x_in : '0;
         bmin_y_ff <= blast2_ff ? min_y_in : '0;
      end
   end

   assign rsp_valid       = v3_ff;
   assign rsp_src_x       = src_x_ff;
   assign rsp_src_y       = src_y_ff;
   assign rsp_block_last  = blast3_ff;
   assign rsp_block_min_x = bmin_x_ff;
   assign rsp_block_min_y = bmin_y_ff;
   assign rsp_frame_last  = flast3_ff;

endmodule

FILE: design/bacg_checker.sv
// Port-level checker of the block affine coordinate generator and its bind.
module bacg_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [bacg_pkg::COORD_W-1:0] rsp_src_x,
   input  logic signed [bacg_pkg::COORD_W-1:0] rsp_src_y,
   input  logic                                rsp_block_last,
   input  logic signed [bacg_pkg::COORD_W-1:0] rsp_block_min_x,
   input  logic signed [bacg_pkg::COORD_W-1:0] rsp_block_min_y,
   input  logic                                rsp_frame_last
);

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_frame_ends_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> rsp_block_last)
      else $error("frame end without block end");

   a_min_zero_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_block_last) |-> (rsp_block_min_x == '0 && rsp_block_min_y == '0))
      else $error("block minimum shown inside a block");

   a_min_bounds_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_block_last) |->
         (rsp_block_min_x <= rsp_src_x && rsp_block_min_y <= rsp_src_y))
      else $error("block minimum above last pixel");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_src_x) && $stable(rsp_src_y)))
      else $error("stalled response changed");

endmodule

bind block_affine_coordinate_generator_top bacg_checker u_bacg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_src_x       (rsp_src_x),
   .rsp_src_y       (rsp_src_y),
   .rsp_block_last  (rsp_block_last),
   .rsp_block_min_x (rsp_block_min_x),
   .rsp_block_min_y (rsp_block_min_y),
   .rsp_frame_last  (rsp_frame_last)
);
